[rtl/core/lrect_pkg.sv]
// Shared constants, types and command/status structs for the largest empty rectangle block.
package lrect_pkg;

    // Grid geometry and value widths.
    localparam int MAX_COLS   = 128;
    localparam int MAX_HEIGHT = 255;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int DEPTH_W    = COL_W + 1;
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int AREA_W     = 15;
    localparam int CFG_W      = 8;
    localparam int SPAN_W     = COL_W + 1;
    localparam int PROD_W     = HEIGHT_W + SPAN_W;
    localparam int CMP_W      = (CFG_W > DEPTH_W) ? CFG_W : DEPTH_W;
    localparam int ENTRY_W    = HEIGHT_W + COL_W;

    // Saturation limit of a reported area.
    localparam logic [AREA_W-1:0] AREA_SAT = {AREA_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input item and read its column height
        logic load;       // form the new height and write it back
        logic pop_scan;   // pop the top against the current column
        logic pop_flush;  // pop the top against the right edge of the row
        logic refill;     // move the registered stack read into the top
        logic push;       // push the new run and advance the column
        logic emit;       // load the result register and clear the grid
    } lrect_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stack_empty;
        logic top_ge;     // top height is at least the new height
        logic row_end;    // this cell closes its row
        logic last;       // this cell closes the grid
        logic out_free;   // result register can take a new item
    } lrect_status_t;

endpackage

[rtl/core/lrect_cell_if.sv]
// Input channel carrying one grid cell per item.
interface lrect_cell_if;
    logic valid;
    logic ready;
    logic cell_blocked;
    logic last_cell;

    modport source (output valid, output cell_blocked, output last_cell, input ready);
    modport sink (input valid, input cell_blocked, input last_cell, output ready);
endinterface

[rtl/core/lrect_area_if.sv]
// Output channel carrying the best area of a finished grid.
interface lrect_area_if;
    logic                         valid;
    logic                         ready;
    logic [lrect_pkg::AREA_W-1:0] best_area;

    modport source (output valid, output best_area, input ready);
    modport sink (input valid, input best_area, output ready);
endinterface

[rtl/core/largest_empty_rectangle.sv]
// Per cell: accept, height load and stack scan, where each pop of the stack adds a refill step;
// a row end adds a flush, which pops and refills once per stacked entry. Each pushed run is popped
// once, and in one-column rows every cell also pays its row-end check and flush.
// The best area reaches the result register from the emit state, which follows the last flush step;
// that emit step waits while the previous result is still held. The next grid may start then.
// Reset: asynchronous active low; heights, stack, column index and best area clear; row width = MAX_COLS.
module largest_empty_rectangle (
    input  logic                        clk,
    input  logic                        rst_n,
    lrect_cell_if.sink                  cells,
    lrect_area_if.source                result,
    input  logic                        cfg_write,
    input  logic [lrect_pkg::CFG_W-1:0] cfg_data
);

    lrect_pkg::lrect_cmd_t    cmd;
    lrect_pkg::lrect_status_t status;

    // Sequencer.
    lrect_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cells.valid),
        .in_ready (cells.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    lrect_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_blocked (cells.cell_blocked),
        .last_cell    (cells.last_cell),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_area     (result.best_area)
    );

endmodule

[rtl/core/lrect_ctrl.sv]
// Sequencer that steps each cell through height update, stack scan and row flush, then emits at a grid end.
module lrect_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  lrect_pkg::lrect_status_t status,
    output lrect_pkg::lrect_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LOAD    = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_REFILL  = 7'b0001000,
        S_FLUSH   = 7'b0010000,
        S_FREFILL = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!status.stack_empty && status.top_ge)
                begin
                    cmd.pop_scan = 1'b1;
                    state_next   = S_REFILL;
                end
                else
                begin
                    cmd.push = 1'b1;
                    if (status.row_end || status.last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_SCAN;
            end
            S_FLUSH:
            begin
                if (!status.stack_empty)
                begin
                    cmd.pop_flush = 1'b1;
                    state_next    = S_FREFILL;
                end
                else if (status.last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_FLUSH;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lrect_datapath.sv]
// Column height memory, run stack with cached top, area tracking and result register.
module lrect_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cell_blocked,
    input  logic                               last_cell,
    input  logic                               cfg_write,
    input  logic [lrect_pkg::CFG_W-1:0]        cfg_data,
    input  lrect_pkg::lrect_cmd_t              cmd,
    output lrect_pkg::lrect_status_t           status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lrect_pkg::AREA_W-1:0]       out_area
);

    // Memories.
    logic [lrect_pkg::HEIGHT_W-1:0] height_mem [lrect_pkg::MAX_COLS];
    logic [lrect_pkg::ENTRY_W-1:0]  stack_mem [lrect_pkg::MAX_COLS];

    // Registers.
    logic [lrect_pkg::MAX_COLS-1:0] hvalid_reg;
    logic [lrect_pkg::HEIGHT_W-1:0] hq_reg;
    logic [lrect_pkg::ENTRY_W-1:0]  sq_reg;
    logic                           blocked_reg;
    logic                           last_reg;
    logic [lrect_pkg::COL_W-1:0]    col_reg;
    logic [lrect_pkg::COL_W-1:0]    colidx_reg;
    logic [lrect_pkg::COL_W-1:0]    colidx_next;
    logic [lrect_pkg::HEIGHT_W-1:0] h_reg;
    logic [lrect_pkg::HEIGHT_W-1:0] h_next;
    logic [lrect_pkg::COL_W-1:0]    start_reg;
    logic [lrect_pkg::HEIGHT_W-1:0] top_h_reg;
    logic [lrect_pkg::COL_W-1:0]    top_s_reg;
    logic [lrect_pkg::DEPTH_W-1:0]  depth_reg;
    logic [lrect_pkg::AREA_W-1:0]   area_reg;
    logic [lrect_pkg::AREA_W-1:0]   area_next;
    logic [lrect_pkg::CFG_W-1:0]    width_reg;
    logic                           out_valid_reg;
    logic [lrect_pkg::AREA_W-1:0]   out_area_reg;

    // Combinational helpers.
    logic [lrect_pkg::HEIGHT_W-1:0] h_base;
    logic [lrect_pkg::CMP_W-1:0]    eff_width;
    logic [lrect_pkg::CMP_W-1:0]    col_plus;
    logic [lrect_pkg::SPAN_W-1:0]   right_edge;
    logic [lrect_pkg::SPAN_W-1:0]   span;
    logic [lrect_pkg::PROD_W-1:0]   product;
    logic [lrect_pkg::AREA_W-1:0]   offered;
    logic                           do_push;
    logic [lrect_pkg::COL_W-1:0]    push_idx;
    logic [lrect_pkg::COL_W-1:0]    read_idx;

    // Effective row width: zero acts as one, anything wide acts as the full grid.
    always_comb
    begin
        eff_width = lrect_pkg::CMP_W'(width_reg);
        if (width_reg == '0)
        begin
            eff_width = lrect_pkg::CMP_W'(1);
        end
        else if (lrect_pkg::CMP_W'(width_reg) > lrect_pkg::CMP_W'(lrect_pkg::MAX_COLS))
        begin
            eff_width = lrect_pkg::CMP_W'(lrect_pkg::MAX_COLS);
        end
    end

    assign col_plus = lrect_pkg::CMP_W'(col_reg) + lrect_pkg::CMP_W'(1);

    // New column height, saturating.
    always_comb
    begin
        h_base = hvalid_reg[col_reg] ? hq_reg : '0;
        if (blocked_reg)
        begin
            h_next = '0;
        end
        else if (h_base < lrect_pkg::HEIGHT_W'(lrect_pkg::MAX_HEIGHT))
        begin
            h_next = h_base + lrect_pkg::HEIGHT_W'(1);
        end
        else
        begin
            h_next = h_base;
        end
    end

    // Area offered by the popped top, against the column or the row edge.
    always_comb
    begin
        right_edge = cmd.pop_flush ? (lrect_pkg::SPAN_W'(col_reg) + lrect_pkg::SPAN_W'(1))
                                   : lrect_pkg::SPAN_W'(col_reg);
        span    = right_edge - lrect_pkg::SPAN_W'(top_s_reg);
        product = lrect_pkg::PROD_W'(top_h_reg) * lrect_pkg::PROD_W'(span);
        if (product > lrect_pkg::PROD_W'(lrect_pkg::AREA_SAT))
        begin
            offered = lrect_pkg::AREA_SAT;
        end
        else
        begin
            offered = product[lrect_pkg::AREA_W-1:0];
        end
        area_next = area_reg;
        if ((cmd.pop_scan || cmd.pop_flush) && (offered > area_reg))
        begin
            area_next = offered;
        end
    end

    // Push decision, stack addresses and next column index.
    always_comb
    begin
        do_push  = cmd.push && (h_reg != '0) &&
                   (depth_reg < lrect_pkg::DEPTH_W'(lrect_pkg::MAX_COLS));
        push_idx = lrect_pkg::COL_W'(depth_reg - lrect_pkg::DEPTH_W'(1));
        read_idx = lrect_pkg::COL_W'(depth_reg - lrect_pkg::DEPTH_W'(2));
        if (last_reg || (col_plus >= eff_width))
        begin
            colidx_next = '0;
        end
        else
        begin
            colidx_next = col_reg + lrect_pkg::COL_W'(1);
        end
    end

    // Column height memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hq_reg <= height_mem[colidx_reg];
        end
        if (cmd.load)
        begin
            height_mem[col_reg] <= h_next;
        end
    end

    // Run stack memory holding every entry below the cached top.
    always_ff @(posedge clk)
    begin
        if (cmd.pop_scan || cmd.pop_flush)
        begin
            sq_reg <= stack_mem[read_idx];
        end
        if (do_push && (depth_reg != '0))
        begin
            stack_mem[push_idx] <= {top_h_reg, top_s_reg};
        end
    end

    // Payload registers for the cell in flight and the cached top.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            blocked_reg <= cell_blocked;
            last_reg    <= last_cell;
            col_reg     <= colidx_reg;
        end
        if (cmd.load)
        begin
            h_reg     <= h_next;
            start_reg <= col_reg;
        end
        else if (cmd.pop_scan)
        begin
            start_reg <= top_s_reg;
        end
        if (do_push)
        begin
            top_h_reg <= h_reg;
            top_s_reg <= start_reg;
        end
        else if (cmd.refill)
        begin
            top_h_reg <= sq_reg[lrect_pkg::ENTRY_W-1:lrect_pkg::COL_W];
            top_s_reg <= sq_reg[lrect_pkg::COL_W-1:0];
        end
        if (cmd.emit)
        begin
            out_area_reg <= area_reg;
        end
    end

    // Control state: valid bits, depth, column index, best area, width, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg    <= '0;
            depth_reg     <= '0;
            colidx_reg    <= '0;
            area_reg      <= '0;
            width_reg     <= lrect_pkg::CFG_W'(lrect_pkg::MAX_COLS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                width_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                hvalid_reg <= '0;
                depth_reg  <= '0;
                colidx_reg <= '0;
                area_reg   <= '0;
            end
            else
            begin
                if (cmd.load)
                begin
                    hvalid_reg[col_reg] <= 1'b1;
                end
                if (cmd.pop_scan || cmd.pop_flush)
                begin
                    depth_reg <= depth_reg - lrect_pkg::DEPTH_W'(1);
                end
                else if (do_push)
                begin
                    depth_reg <= depth_reg + lrect_pkg::DEPTH_W'(1);
                end
                if (cmd.push)
                begin
                    colidx_reg <= colidx_next;
                end
                area_reg <= area_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.stack_empty = (depth_reg == '0);
        status.top_ge      = (top_h_reg >= h_reg);
        status.row_end     = (col_plus >= eff_width);
        status.last        = last_reg;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_area  = out_area_reg;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the largest empty rectangle block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A cell fed to the block.
    typedef struct packed {
        logic blocked;
        logic last;
    } cell_item_t;

    // Settling wait before a width write; a cell with a full stack, plus a full flush, fits inside it.
    localparam int SETTLE_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write;
    logic [lrect_pkg::CFG_W-1:0]   cfg_data;

    lrect_cell_if cell_ch ();
    lrect_area_if area_ch ();

    largest_empty_rectangle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cell_ch),
        .result    (area_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Cells waiting to be sent and areas waiting to come back.
    cell_item_t                    pending_cells[$];
    logic [lrect_pkg::AREA_W-1:0]  pending_areas[$];

    int sender_idle_pct = 31;
    int receiver_idle_pct = 78;
    int fail_count = 0;
    int quiet_cycles = 0;

    // Predicted grid state.
    bit [lrect_pkg::HEIGHT_W-1:0]  col_height [lrect_pkg::MAX_COLS];
    bit [lrect_pkg::HEIGHT_W-1:0]  run_height [lrect_pkg::MAX_COLS];
    bit [lrect_pkg::COL_W-1:0]     run_start [lrect_pkg::MAX_COLS];
    int                            run_depth;
    int                            next_col;
    bit [lrect_pkg::AREA_W-1:0]    area_best;
    bit [lrect_pkg::CFG_W-1:0]     width_reg;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        fail_count++;
    endtask

    // Columns per row as the block applies the register.
    function automatic int active_width();
        int w;
        w = width_reg;
        if (w == 0)
            w = 1;
        if (w > lrect_pkg::MAX_COLS)
            w = lrect_pkg::MAX_COLS;
        return w;
    endfunction

    // Offer the rectangle of one popped run to the running best.
    function automatic void credit_run(input int h, input int left, input int right);
        int a;
        if (right <= left)
            return;
        a = h * (right - left);
        if (a > lrect_pkg::AREA_SAT)
            a = lrect_pkg::AREA_SAT;
        if (a > area_best)
            area_best = lrect_pkg::AREA_W'(a);
    endfunction

    // Advance the predicted grid by one accepted cell.
    function automatic void scan_cell(input bit blocked, input bit last);
        int w;
        int col;
        int h;
        int start;
        w = active_width();
        col = next_col;
        if (col >= lrect_pkg::MAX_COLS)
            col = lrect_pkg::MAX_COLS - 1;

        if (blocked)
            h = 0;
        else
        begin
            h = col_height[col];
            if (h < lrect_pkg::MAX_HEIGHT)
                h++;
        end
        col_height[col] = lrect_pkg::HEIGHT_W'(h);

        // Pop every run at least as high as the new height.
        start = col;
        while (run_depth > 0 && run_height[run_depth-1] >= h)
        begin
            credit_run(run_height[run_depth-1], run_start[run_depth-1], col);
            start = run_start[run_depth-1];
            run_depth--;
        end
        if (h > 0 && run_depth < lrect_pkg::MAX_COLS)
        begin
            run_height[run_depth] = lrect_pkg::HEIGHT_W'(h);
            run_start[run_depth] = lrect_pkg::COL_W'(start);
            run_depth++;
        end

        // Flush against the right edge at a row end or at the grid end.
        if (last || col + 1 >= w)
        begin
            while (run_depth > 0)
            begin
                credit_run(run_height[run_depth-1], run_start[run_depth-1], col + 1);
                run_depth--;
            end
            next_col = 0;
        end
        else
            next_col = col + 1;

        if (last)
        begin
            pending_areas.push_back(area_best);
            foreach (col_height[i])
                col_height[i] = '0;
            run_depth = 0;
            next_col = 0;
            area_best = '0;
        end
    endfunction

    // Cell driver: holds an item until it is taken, idles at random.
    always @(posedge clk)
    begin : cell_driver
        cell_item_t nxt;
        if (!rst_n)
            cell_ch.valid <= 1'b0;
        else
        begin
            if (cell_ch.valid && cell_ch.ready)
                scan_cell(cell_ch.cell_blocked, cell_ch.last_cell);
            if (!cell_ch.valid || cell_ch.ready)
            begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = pending_cells.pop_front();
                    cell_ch.valid <= 1'b1;
                    cell_ch.cell_blocked <= nxt.blocked;
                    cell_ch.last_cell <= nxt.last;
                end
                else
                begin
                    cell_ch.valid <= 1'b0;
                    cell_ch.cell_blocked <= 1'($urandom_range(1));
                    cell_ch.last_cell <= 1'($urandom_range(1));
                end
            end
        end
    end

    // Area monitor: checks each taken item against the oldest prediction.
    always @(posedge clk)
    begin : area_monitor
        logic [lrect_pkg::AREA_W-1:0] want;
        if (!rst_n)
            area_ch.ready <= 1'b0;
        else
        begin
            if (area_ch.valid && area_ch.ready)
            begin
                if (pending_areas.size() == 0)
                    report_mismatch("best_area with no grid pending", 0, area_ch.best_area);
                else
                begin
                    want = pending_areas.pop_front();
                    if (area_ch.best_area !== want)
                        report_mismatch("best_area", want, area_ch.best_area);
                end
            end
            area_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((cell_ch.valid && cell_ch.ready) || (area_ch.valid && area_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_cell(input bit blocked, input bit last);
        cell_item_t c;
        c.blocked = blocked;
        c.last = last;
        pending_cells.push_back(c);
    endtask

    // Cells that do not close the grid.
    task automatic queue_run(input int count, input int blocked_pct);
        repeat (count)
            queue_cell($urandom_range(99) < blocked_pct, 1'b0);
    endtask

    // One grid of whole rows, optionally cut short inside its last row.
    task automatic queue_grid(input int rows, input int blocked_pct, input bit cut);
        int w;
        int total;
        w = active_width();
        total = rows * w;
        if (cut && w > 1)
            total -= $urandom_range(w - 1, 1);
        for (int i = 0; i < total; i++)
            queue_cell($urandom_range(99) < blocked_pct, i == total - 1);
    endtask

    // Several grids with random size and density.
    task automatic queue_grids(input int count, input int max_rows);
        int pct;
        repeat (count)
        begin
            case ($urandom_range(4))
                0: pct = 0;
                1: pct = 5;
                2: pct = 20;
                3: pct = 45;
                default: pct = 90;
            endcase
            queue_grid($urandom_range(max_rows, 1), pct, $urandom_range(2) == 0);
        end
    endtask

    // Wait until every cell is taken and every area has come back.
    task automatic drain();
        while (pending_cells.size() != 0 || cell_ch.valid || pending_areas.size() != 0)
            @(negedge clk);
    endtask

    // Width writes happen only once the block has gone quiet.
    task automatic write_width(input int value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= lrect_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        width_reg = lrect_pkg::CFG_W'(value);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_blocked = 1'b0;
        cell_ch.last_cell = 1'b0;
        area_ch.ready = 1'b0;
        run_depth = 0;
        next_col = 0;
        area_best = '0;
        width_reg = lrect_pkg::CFG_W'(lrect_pkg::MAX_COLS);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset width: a short grid that ends inside its first row.
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b1);

        // A zero width acts as one column: a free column, then a lone blocked cell.
        write_width(0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b1);
        queue_cell(1'b1, 1'b1);

        // Two columns: a broken free block, then an all-blocked grid.
        write_width(2);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b1);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b1);

        // Narrow the width while a row is open past the new edge.
        write_width(4);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        write_width(2);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b0, 1'b1);

        // One column deep enough to saturate the height, then small grids.
        write_width(1);
        queue_grid(260, 0, 1'b0);
        queue_grids(4, 12);

        drain();
        sender_idle_pct = 78;
        receiver_idle_pct = 31;

        // An oversized width acts as the full grid width.
        write_width(255);
        queue_grid(1, 15, 1'b0);
        write_width(3);
        queue_grids(12, 5);
        queue_run(2, 30);

        drain();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;

        write_width($urandom_range(10, 4));
        queue_grids(6, 4);
        write_width(lrect_pkg::MAX_COLS);
        queue_grid(1, 10, 1'b1);
        write_width($urandom_range(9, 2));
        queue_grids(4, 6);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
